[hw/rtl/ipv4fmt_pkg.sv]
// Shared types, constants and the octet-to-decimal helper for the
// IPv4 dotted-decimal formatter. No dependencies.
`default_nettype none

package ipv4fmt_pkg;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned OCTETS     = 4;
  localparam int unsigned TEXT_CHARS = 15;
  localparam int unsigned TEXT_W     = 8 * TEXT_CHARS;
  localparam int unsigned LO_W       = 64;
  localparam int unsigned HI_W       = 56;
  localparam int unsigned LEN_W      = 4;
  localparam int unsigned OFF_W      = 4;
  localparam int unsigned FRAG_W     = 32;
  localparam int unsigned S_DATA_W   = 32;
  localparam int unsigned M_DATA_W   = 128;

  localparam logic [7:0] CHAR_DOT  = 8'h2E;
  localparam logic [7:0] CHAR_ZERO = 8'h30;

  // Digits left-justified: first digit in bits 7:0, zero past the last digit.
  typedef struct packed {
    logic [23:0] chars;
    logic [1:0]  len;
  } octet_fmt_t;

  function automatic octet_fmt_t fmt_octet(input logic [7:0] v);
    octet_fmt_t  r;
    logic [1:0]  hund;
    logic [7:0]  rest;
    logic [15:0] prod;
    logic [3:0]  tens;
    logic [3:0]  ones;
    logic [7:0]  tens10;
    if (v >= 8'd200) begin
      hund = 2'd2;
      rest = v - 8'd200;
    end else if (v >= 8'd100) begin
      hund = 2'd1;
      rest = v - 8'd100;
    end else begin
      hund = 2'd0;
      rest = v;
    end
    // rest < 100: floor(rest/10) == (rest*205) >> 11
    prod   = 16'(rest) * 16'd205;
    tens   = prod[14:11];
    tens10 = 8'(tens) * 8'd10;
    ones   = 4'(rest - tens10);
    if (v < 8'd10) begin
      r.chars = {16'h0, CHAR_ZERO + 8'(ones)};
      r.len   = 2'd1;
    end else if (v < 8'd100) begin
      r.chars = {8'h0, CHAR_ZERO + 8'(ones), CHAR_ZERO + 8'(tens)};
      r.len   = 2'd2;
    end else begin
      r.chars = {CHAR_ZERO + 8'(ones), CHAR_ZERO + 8'(tens), CHAR_ZERO + 8'(hund)};
      r.len   = 2'd3;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/ipv4fmt_place.sv]
// Places the four per-octet fragments at their byte offsets in the text.
// Depends on ipv4fmt_pkg.
`default_nettype none

module ipv4fmt_place (
  input  wire logic [ipv4fmt_pkg::OCTETS-1:0][ipv4fmt_pkg::FRAG_W-1:0] frag,
  input  wire logic [ipv4fmt_pkg::OCTETS-1:0][ipv4fmt_pkg::OFF_W-1:0]  off,
  output logic [ipv4fmt_pkg::TEXT_W-1:0]                               text
);

  always_comb begin
    text = '0;
    for (int i = 0; i < ipv4fmt_pkg::OCTETS; i++) begin
      // fragments never overlap, so OR merges them
      text = text | (ipv4fmt_pkg::TEXT_W'(frag[i]) << {off[i], 3'b000});
    end
  end

endmodule

`default_nettype wire

[hw/rtl/ipv4_dotted_decimal_formatter_core.sv]
// IPv4 dotted-decimal formatter, top level: three-stage elastic pipeline.
// Depends on ipv4fmt_pkg and ipv4fmt_place.
//
// Usage:
//   Slave channel s_*: one 32-bit address per transaction, first octet in
//   bits 31:24.
//   Master channel m_*: one result per address: text_first_eight (chars 0-7),
//   text_last_seven (chars 8-14) and text_length (7 to 15). Bytes past the
//   end of the text are zero.
//   Timing: the address is registered in stage A, then in stage B, then in
//   stage C, which drives m_tvalid; it is taken at an edge with m_tready high.
//   Throughput: one address per cycle while m_tready is high; each of
//   the three stages (digit conversion, fragment and offset build, byte
//   placement into the output register) holds one item.
//   Reset: rst clears all stage valid bits; no result is pending after it.
//   Stall: when m_tready is low the output holds; stages behind it keep
//   filling until the pipeline is full, then s_tready drops. Nothing is lost
//   or repeated.
`default_nettype none

module ipv4_dotted_decimal_formatter_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // [31:0] address
  input  wire logic [ipv4fmt_pkg::S_DATA_W-1:0]    s_tdata,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // [63:0] text_first_eight, [119:64] text_last_seven,
  // [123:120] text_length, [127:124] zero
  output logic [ipv4fmt_pkg::M_DATA_W-1:0]         m_tdata
);

  // stage A: per-octet decimal digits
  logic                                                  a_valid;
  ipv4fmt_pkg::octet_fmt_t [ipv4fmt_pkg::OCTETS-1:0]     a_oct;
  // stage B: fragments with dots and their byte offsets
  logic                                                  b_valid;
  logic [ipv4fmt_pkg::OCTETS-1:0][ipv4fmt_pkg::FRAG_W-1:0] b_frag;
  logic [ipv4fmt_pkg::OCTETS-1:0][ipv4fmt_pkg::OFF_W-1:0]  b_off;
  logic [ipv4fmt_pkg::LEN_W-1:0]                         b_len;
  // stage C: output register
  logic                                                  c_valid;
  logic [ipv4fmt_pkg::TEXT_W-1:0]                        c_text;
  logic [ipv4fmt_pkg::LEN_W-1:0]                         c_len;

  logic a_rdy, b_rdy, c_rdy;
  logic [ipv4fmt_pkg::OCTETS-1:0][ipv4fmt_pkg::FRAG_W-1:0] frag_next;
  logic [ipv4fmt_pkg::OCTETS-1:0][ipv4fmt_pkg::OFF_W-1:0]  off_next;
  logic [ipv4fmt_pkg::LEN_W-1:0]                         len_next;
  logic [ipv4fmt_pkg::TEXT_W-1:0]                        text_next;

  assign c_rdy    = !c_valid || m_tready;
  assign b_rdy    = !b_valid || c_rdy;
  assign a_rdy    = !a_valid || b_rdy;
  assign s_tready = a_rdy;

  always_comb begin
    for (int i = 0; i < ipv4fmt_pkg::OCTETS; i++) begin
      frag_next[i] = ipv4fmt_pkg::FRAG_W'(a_oct[i].chars);
      if (i < ipv4fmt_pkg::OCTETS - 1) begin
        frag_next[i] = frag_next[i] |
                       (ipv4fmt_pkg::FRAG_W'(ipv4fmt_pkg::CHAR_DOT) << {a_oct[i].len, 3'b000});
      end
    end
    off_next[0] = '0;
    for (int i = 1; i < ipv4fmt_pkg::OCTETS; i++) begin
      off_next[i] = off_next[i-1] + ipv4fmt_pkg::OFF_W'(a_oct[i-1].len) + 4'd1;
    end
    len_next = off_next[ipv4fmt_pkg::OCTETS-1] +
               ipv4fmt_pkg::LEN_W'(a_oct[ipv4fmt_pkg::OCTETS-1].len);
  end

  ipv4fmt_place u_place (
    .frag (b_frag),
    .off  (b_off),
    .text (text_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (a_rdy) a_valid <= s_tvalid;
      if (b_rdy) b_valid <= a_valid;
      if (c_rdy) c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy && s_tvalid) begin
      for (int i = 0; i < ipv4fmt_pkg::OCTETS; i++) begin
        // octet 0 is the most significant byte
        a_oct[i] <= ipv4fmt_pkg::fmt_octet(s_tdata[8*(ipv4fmt_pkg::OCTETS-1-i) +: 8]);
      end
    end
    if (b_rdy && a_valid) begin
      b_frag <= frag_next;
      b_off  <= off_next;
      b_len  <= len_next;
    end
    if (c_rdy && b_valid) begin
      c_text <= text_next;
      c_len  <= b_len;
    end
  end

  assign m_tvalid = c_valid;
  assign m_tdata  = {4'h0, c_len, c_text};

endmodule

`default_nettype wire

[hw/rtl/ipv4fmt_checker.sv]
// Port-level checks for the IPv4 dotted-decimal formatter, bound to the top.
// Depends on ipv4_dotted_decimal_formatter_core.
`default_nettype none

module ipv4fmt_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [127:0] m_tdata
);

  // output stall: result must hold until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result pending after reset");

  a_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[123:120] >= 4'd7 && m_tdata[127:124] == 4'h0)
    else $error("text length out of range");

  // short text leaves the upper field empty; first char is a digit
  a_short: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[123:120] <= 4'd8 |->
      m_tdata[119:64] == '0 && m_tdata[7:4] == 4'h3)
    else $error("bad short text");

endmodule

bind ipv4_dotted_decimal_formatter_core ipv4fmt_checker u_ipv4fmt_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
